// ===== hdl/indexed_array_list_core_defines.svh =====
// Assertion macros shared by the array list core.
// No dependencies; included by files that carry concurrent checks.
`ifndef INDEXED_ARRAY_LIST_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define IAL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define IAL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ial_pkg.sv =====
// Types, codes and sizes for the array list core.
// No dependencies; imported by ial_cell, indexed_array_list_core and the testbench.
`timescale 1ns / 1ps

package ial_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned FILL_W   = 7;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_INSERT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell for one request.
  typedef struct packed {
    logic             go;     // request succeeds, cells update
    func_e            func;
    logic [CNT_W-1:0] pos;    // target index, zero-extended
    logic [CNT_W-1:0] count;  // entries held before the request
    logic [CNT_W-1:0] last;   // count - 1
    data_t            value;
  } ctrl_t;

endpackage

// ===== hdl/ial_cell.sv =====
// One slot of the list: holds a word, shifts with its neighbors.
// Depends on ial_pkg.
`timescale 1ns / 1ps

module ial_cell
  import ial_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,       // fixed slot number
  input  ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0] rd_idx_i,
  input  data_t            left_i,      // slot idx-1
  input  data_t            right_i,     // slot idx+1
  output data_t            data_o,
  output data_t            rd_data_o
);

  logic [CNT_W-1:0] ix;
  data_t            data_d, data_q;

  assign ix = CNT_W'(idx_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.go) begin
      case (ctrl_i.func)
        FN_APPEND: begin
          if (ix == ctrl_i.count) data_d = ctrl_i.value;
        end
        FN_POP: begin
          if (ix == ctrl_i.last) data_d = '0;
        end
        FN_REMOVE: begin
          if (ix == ctrl_i.last) data_d = '0;
          else if (ix >= ctrl_i.pos && ix < ctrl_i.last) data_d = right_i;
        end
        default: begin
          if (ix == ctrl_i.pos) data_d = ctrl_i.value;
          else if (ix > ctrl_i.pos && ix <= ctrl_i.count) data_d = left_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o    = data_q;
  assign rd_data_o = (ix == rd_idx_i) ? data_q : '0;

endmodule

// ===== hdl/indexed_array_list_core.sv =====
// Array list core: the result of each input transfer is registered in the output register.
// Throughput: one request per cycle while the output is not stalled; the whole row of cells shifts in the same cycle.
// A stalled output holds the next request back only while the result register is full.
// Reset (rst_ni low, asynchronous) empties the list and clears every slot to zero.
// Depends on ial_pkg, ial_cell and indexed_array_list_core_defines.svh.
`timescale 1ns / 1ps
`include "indexed_array_list_core_defines.svh"

module indexed_array_list_core
  import ial_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] data_in, [37:32] position, [39:38] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data_out, [38:32] fill_count, [39] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic             in_xfer;
  func_e            func;
  data_t            data_in;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] pos_ext;

  logic [CNT_W-1:0] count_d, count_q;
  logic [CNT_W-1:0] last;
  logic             full, empty, out_of_range;
  status_e          status;
  ctrl_t            ctrl;
  logic [CNT_W-1:0] rd_idx;

  assign func     = func_e'(s_axis_tuser);
  assign data_in  = s_axis_tdata[DATA_W-1:0];
  assign position = s_axis_tdata[DATA_W+POS_W-1:DATA_W];
  assign pos_ext  = CNT_W'(position);

  // The result register empties on a downstream transfer, so a new request
  // can enter in the same cycle the old result leaves.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign last         = count_q - CNT_W'(1);
  assign full         = (count_q == CNT_W'(CAPACITY));
  assign empty        = (count_q == '0);
  assign out_of_range = (32'(position) >= 32'(count_q));   // covers empty as well

  // Index is checked before the full test on insert.
  always_comb begin
    case (func)
      FN_APPEND: status = full ? ST_FULL : ST_OK;
      FN_POP:    status = empty ? ST_RANGE : ST_OK;
      FN_REMOVE: status = out_of_range ? ST_RANGE : ST_OK;
      default:   status = out_of_range ? ST_RANGE : (full ? ST_FULL : ST_OK);
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (in_xfer && status == ST_OK) begin
      case (func) inside
        FN_APPEND, FN_INSERT: count_d = count_q + CNT_W'(1);
        default:              count_d = last;
      endcase
    end
  end

  // Pop reads the tail; remove reads the addressed slot.
  assign rd_idx = (func == FN_POP) ? last : pos_ext;

  assign ctrl.go    = in_xfer && (status == ST_OK);
  assign ctrl.func  = func;
  assign ctrl.pos   = pos_ext;
  assign ctrl.count = count_q;
  assign ctrl.last  = last;
  assign ctrl.value = data_in;

  // ---------------------------------------------------------------------------
  // Row of cells; each hands its word to both neighbors every cycle
  // ---------------------------------------------------------------------------
  data_t cell_data [CAPACITY];
  data_t cell_rd   [CAPACITY];
  data_t removed;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    ial_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(g)),
      .ctrl_i    (ctrl),
      .rd_idx_i  (rd_idx),
      .left_i    (left_w),
      .right_i   (right_w),
      .data_o    (cell_data[g]),
      .rd_data_o (cell_rd[g])
    );
  end

  // Only the addressed cell drives a nonzero word.
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_rd[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic    out_valid_d, out_valid_q;
  data_t   data_out_d, data_out_q;
  status_e status_d, status_q;
  logic [FILL_W-1:0] fill_d, fill_q;

  always_comb begin
    out_valid_d = out_valid_q;
    data_out_d  = data_out_q;
    status_d    = status_q;
    fill_d      = fill_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      status_d    = status;
      fill_d      = FILL_W'(count_d);
      data_out_d  = (status == ST_OK && (func == FN_POP || func == FN_REMOVE))
                    ? removed : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_out_q <= data_out_d;
    status_q   <= status_d;
    fill_q     <= fill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, fill_q, data_out_q};
  assign m_axis_tuser  = status_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `IAL_ASSERT_ALWAYS(a_count_cap, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY),
    "entry count above capacity")
  `IAL_ASSERT_IMPL(a_full_fill, clk_i, rst_ni,
    m_axis_tvalid && status_q == ST_FULL, fill_q == FILL_W'(CAPACITY),
    "full status with list not full")
  `IAL_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni,
    m_axis_tvalid && status_q != ST_OK, data_out_q == '0,
    "failed request returned data")
  `IAL_ASSERT_IMPL(a_fill_track, clk_i, rst_ni,
    m_axis_tvalid, fill_q == FILL_W'(count_q),
    "reported fill differs from entry count")

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for indexed_array_list_core: directed and random list requests.
// Needs ial_pkg and the core; results are checked against an in-bench list predictor.
`timescale 1ns / 1ps

module testbench;
  import ial_pkg::*;

  typedef struct {
    func_e          func;
    data_t          data_in;
    logic [POS_W-1:0] position;
    bit             drain_first;  // hold this request until the list core is quiet
  } list_req_t;

  typedef struct {
    data_t             removed;
    status_e           status;
    logic [FILL_W-1:0] fill;
  } list_result_t;

  localparam int QUIET_TAIL = 40;  // last requests go out with no idling

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [31:0] data_in, [37:32] position, [39:38] zero
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] data_out, [38:32] fill_count, [39] zero
  logic [1:0]  m_axis_tuser;   // [1:0] status

  indexed_array_list_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  list_req_t    request_queue[$];
  list_result_t predicted_results[$];
  list_req_t    req_on_bus;

  // Predictor state
  data_t list_words [CAPACITY];
  int    list_len;

  // Stimulus shaping only: entry count as the generator sees it
  int gen_count;

  int error_count;
  int sent_count;
  int ok_seen, range_seen, full_seen, peak_fill;

  function automatic list_result_t apply_request(list_req_t req);
    list_result_t res;
    res.removed = '0;
    res.status  = ST_OK;
    case (req.func)
      FN_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = req.data_in;
          list_len++;
        end
      end
      FN_POP: begin
        if (list_len == 0) begin
          res.status = ST_RANGE;
        end else begin
          list_len--;
          res.removed = list_words[list_len];
          list_words[list_len] = '0;
        end
      end
      FN_REMOVE: begin
        if (int'(req.position) >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.removed = list_words[req.position];
          for (int k = int'(req.position); k + 1 < list_len; k++)
            list_words[k] = list_words[k + 1];
          list_len--;
          list_words[list_len] = '0;
        end
      end
      default: begin
        // index check comes before the full check
        if (int'(req.position) >= list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int k = list_len; k > int'(req.position); k--)
            list_words[k] = list_words[k - 1];
          list_words[req.position] = req.data_in;
          list_len++;
        end
      end
    endcase
    res.fill = FILL_W'(list_len);
    return res;
  endfunction

  task automatic add_req(func_e f, data_t v, int p, bit drain = 1'b0);
    list_req_t r;
    r.func        = f;
    r.data_in     = v;
    r.position    = POS_W'(p);
    r.drain_first = drain;
    request_queue.push_back(r);
    case (f)
      FN_APPEND: if (gen_count < CAPACITY) gen_count++;
      FN_POP:    if (gen_count > 0) gen_count--;
      FN_REMOVE: if (p < gen_count) gen_count--;
      default:   if (p < gen_count && gen_count < CAPACITY) gen_count++;
    endcase
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Mostly a valid index, sometimes anywhere in the field
  function automatic int rand_pos();
    if (gen_count > 0 && $urandom_range(0, 9) < 8)
      return $urandom_range(0, gen_count - 1);
    return $urandom_range(0, 2**POS_W - 1);
  endfunction

  task automatic add_random(int grow_pct, bit drain = 1'b0);
    func_e f;
    if ($urandom_range(0, 99) < grow_pct)
      f = ($urandom_range(0, 3) == 0) ? FN_INSERT : FN_APPEND;
    else
      f = ($urandom_range(0, 1) == 0) ? FN_POP : FN_REMOVE;
    add_req(f, rand_value(), rand_pos(), drain);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: presents queued requests, predicts at each accepted transfer
  int send_gap, send_idle_pct, send_cycle;
  always @(posedge clk_i or negedge rst_ni) begin
    list_req_t nxt;
    bit        may_idle;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= FN_APPEND;
      send_gap      <= 0;
      send_idle_pct <= 0;
      send_cycle    <= 0;
    end else begin
      send_cycle <= send_cycle + 1;
      if (send_cycle % 128 == 0)
        send_idle_pct <= $urandom_range(0, 3) * 15;
      may_idle = request_queue.size() >= QUIET_TAIL;
      if (s_axis_tvalid && s_axis_tready) begin
        list_result_t res;
        res = apply_request(req_on_bus);
        predicted_results.push_back(res);
        sent_count++;
        case (res.status)
          ST_OK:    ok_seen++;
          ST_RANGE: range_seen++;
          default:  full_seen++;
        endcase
        if (list_len > peak_fill) peak_fill = list_len;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (may_idle && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap      <= $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() > 0 &&
                     (!request_queue[0].drain_first || predicted_results.size() == 0)) begin
          nxt = request_queue.pop_front();
          req_on_bus    <= nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, nxt.position, nxt.data_in};
          s_axis_tuser  <= nxt.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, checks every result transfer in order
  int recv_gap, recv_idle_pct, recv_cycle;
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    data_t        got_data;
    logic [FILL_W-1:0] got_fill;
    status_e      got_status;
    bit           may_idle;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      recv_idle_pct <= 0;
      recv_cycle    <= 0;
    end else begin
      recv_cycle <= recv_cycle + 1;
      if (recv_cycle % 128 == 64)
        recv_idle_pct <= $urandom_range(0, 3) * 15;
      may_idle = request_queue.size() >= QUIET_TAIL;
      if (m_axis_tvalid && m_axis_tready) begin
        got_data   = m_axis_tdata[31:0];
        got_fill   = m_axis_tdata[38:32];
        got_status = status_e'(m_axis_tuser);
        if (predicted_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: result with nothing pending: data %0d status %0d fill %0d",
                     got_data, got_status, got_fill);
        end else begin
          want = predicted_results.pop_front();
          if (got_data !== want.removed || got_status !== want.status ||
              got_fill !== want.fill) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR: data %0d/%0d status %0d/%0d fill %0d/%0d (expected/actual)",
                       want.removed, got_data, want.status, got_status,
                       want.fill, got_fill);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (may_idle && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap      <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int total;
    int mode;
    int extra;
    rst_ni      = 1'b0;
    list_len    = 0;
    gen_count   = 0;
    error_count = 0;
    sent_count  = 0;
    ok_seen     = 0;
    range_seen  = 0;
    full_seen   = 0;
    peak_fill   = 0;
    foreach (list_words[i]) list_words[i] = '0;

    // Directed: empty-list errors, field extremes, every operation
    add_req(FN_POP,    '0, 0);
    add_req(FN_REMOVE, '0, 0);
    add_req(FN_INSERT, 32'sh1234_5678, 0);
    add_req(FN_REMOVE, '0, 63);
    add_req(FN_APPEND, 32'sh7fff_ffff, 63);
    add_req(FN_APPEND, 32'sh8000_0000, 0);
    add_req(FN_APPEND, '0, 0);
    add_req(FN_APPEND, '1, 21);
    add_req(FN_APPEND, 32'sh5555_5555, 42);
    add_req(FN_INSERT, 32'shaaaa_aaaa, 0);
    add_req(FN_INSERT, 32'sh0f0f_0f0f, 5);    // at the last entry
    add_req(FN_INSERT, 32'sh7777_7777, 7);    // index equal to count
    add_req(FN_INSERT, 32'sh0000_0001, 63);
    add_req(FN_REMOVE, '0, 6);                // last entry
    add_req(FN_REMOVE, '0, 0);
    add_req(FN_REMOVE, '0, 2);
    add_req(FN_REMOVE, '0, 63);
    add_req(FN_POP,    '0, 63);
    add_req(FN_POP,    '0, 0, 1'b1);
    add_req(FN_POP,    '0, 0);
    add_req(FN_POP,    '0, 0);
    add_req(FN_POP,    '0, 0);                // empty again

    // Random: fill to full and beyond, drain to empty and beyond, mixed runs
    total = 0;
    mode  = 0;
    while (total < 450) begin
      case (mode)
        0: begin
          extra = $urandom_range(2, 6);
          while (total < 450 && extra > 0) begin
            add_random(90, total % 100 == 0);
            total++;
            if (gen_count == CAPACITY) extra--;
          end
        end
        1: begin
          extra = $urandom_range(2, 6);
          while (total < 450 && extra > 0) begin
            add_random(15, total % 100 == 0);
            total++;
            if (gen_count == 0) extra--;
          end
        end
        default: begin
          repeat ($urandom_range(20, 50)) begin
            add_random(55);
            total++;
          end
        end
      endcase
      mode = $urandom_range(0, 2);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (predicted_results.size() != 0) error_count++;
    $display("Ran %0d requests: %0d ok, %0d out of range, %0d full; peak fill %0d.",
             sent_count, ok_seen, range_seen, full_seen, peak_fill);
    $display("Mismatches or stray results: %0d", error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
